@@ src/rmq_pkg.sv @@
// ----------------------------------------------------------------------------
// rmq_pkg
// Shared widths, constants and payload types of the rotation matrix to
// quaternion pipeline.
// ----------------------------------------------------------------------------
package rmq_pkg;

	localparam int FRAC_BITS = 14;
	localparam int IN_W      = 16;
	localparam int QW_W      = 15;
	localparam int MAG_MAX   = 32767;

	// signed sum of one and three diagonal entries
	localparam int SUM_W     = ((FRAC_BITS > IN_W + 1) ? FRAC_BITS : IN_W + 1) + 2;
	localparam int MAG_W     = SUM_W - 1;
	localparam int ROOT_MIN  = (MAG_W + FRAC_BITS - 2 + 1) / 2;

	// root bits resolved per pipeline stage
	localparam int SQ_STEPS  = 3;
	localparam int SQ_STAGES = (ROOT_MIN + SQ_STEPS - 1) / SQ_STEPS;
	localparam int ROOT_W    = SQ_STAGES * SQ_STEPS;
	localparam int RAD_W     = 2 * ROOT_W;
	localparam int REM_W     = ROOT_W + 3;

	localparam int LANES  = 4;
	localparam int LANE_W = 0;
	localparam int LANE_X = 1;
	localparam int LANE_Y = 2;
	localparam int LANE_Z = 3;

	localparam int SGN_X = 0;
	localparam int SGN_Y = 1;
	localparam int SGN_Z = 2;

	typedef struct packed {
		logic signed [IN_W-1:0] r00;
		logic signed [IN_W-1:0] r01;
		logic signed [IN_W-1:0] r02;
		logic signed [IN_W-1:0] r10;
		logic signed [IN_W-1:0] r11;
		logic signed [IN_W-1:0] r12;
		logic signed [IN_W-1:0] r20;
		logic signed [IN_W-1:0] r21;
		logic signed [IN_W-1:0] r22;
	} mat_t;

	typedef struct packed {
		logic        [QW_W-1:0] qw;
		logic signed [IN_W-1:0] qx;
		logic signed [IN_W-1:0] qy;
		logic signed [IN_W-1:0] qz;
	} quat_t;

	typedef struct packed {
		logic [RAD_W-1:0]  rad;
		logic [REM_W-1:0]  rem;
		logic [ROOT_W-1:0] root;
	} lane_t;

	typedef struct packed {
		logic [2:0]             neg;
		lane_t [LANES-1:0]      lane;
	} sq_stage_t;

endpackage

@@ src/rotation_matrix_to_quaternion_top.sv @@
// ----------------------------------------------------------------------------
// rotation_matrix_to_quaternion_top
// Converts a Q2.14 rotation matrix to a quaternion through a fully pipelined
// datapath: entry stage, square-root stages, output stage.
//
//   Channel   Handshake        Payload            Transfer
//   matrix    start / busy     mat  (mat_t)       start high, busy low
//   result    done (strobe)    quat (quat_t)      done high, one cycle
//
// The pipeline has one entry stage, one stage per three root bits of the
// four parallel square-root lanes and one output stage. A new matrix is
// taken every cycle; busy is always low. Reset clears the valid bits only.
// The receiver cannot stall, so nothing is held.
// ----------------------------------------------------------------------------
module rotation_matrix_to_quaternion_top (
	input  logic           clk,
	input  logic           arst_n,
	input  logic           start,
	output logic           busy,
	input  rmq_pkg::mat_t  mat,
	output logic           done,
	output rmq_pkg::quat_t quat
);

	logic               vld_s1;
	rmq_pkg::sq_stage_t prep_s1;
	logic               sq_vld_s2 [rmq_pkg::SQ_STAGES];
	rmq_pkg::sq_stage_t sq_s2     [rmq_pkg::SQ_STAGES];
	rmq_pkg::sq_stage_t sq_in     [rmq_pkg::SQ_STAGES];
	rmq_pkg::sq_stage_t sq_next   [rmq_pkg::SQ_STAGES];

	assign busy = 1'b0;

	rmq_prep u_prep (
		.clk     (clk),
		.arst_n  (arst_n),
		.start   (start),
		.mat     (mat),
		.vld_s1  (vld_s1),
		.prep_s1 (prep_s1)
	);

	for (genvar s = 0; s < rmq_pkg::SQ_STAGES; s++) begin : g_stage
		if (s == 0) begin : g_first
			assign sq_in[s] = prep_s1;
		end else begin : g_rest
			assign sq_in[s] = sq_s2[s-1];
		end

		assign sq_next[s].neg = sq_in[s].neg;

		for (genvar k = 0; k < rmq_pkg::LANES; k++) begin : g_lane
			rmq_sqrt_step u_step (
				.lane_in  (sq_in[s].lane[k]),
				.lane_out (sq_next[s].lane[k])
			);
		end

		always_ff @(posedge clk or negedge arst_n) begin
			if (!arst_n) begin
				sq_vld_s2[s] <= 1'b0;
			end else if (s == 0) begin
				sq_vld_s2[s] <= vld_s1;
			end else begin
				sq_vld_s2[s] <= sq_vld_s2[(s == 0) ? 0 : s-1];
			end
		end

		always_ff @(posedge clk) begin
			sq_s2[s] <= sq_next[s];
		end
	end

	rmq_out u_out (
		.clk    (clk),
		.arst_n (arst_n),
		.vld    (sq_vld_s2[rmq_pkg::SQ_STAGES-1]),
		.fin    (sq_s2[rmq_pkg::SQ_STAGES-1]),
		.done   (done),
		.quat   (quat)
	);

endmodule

@@ src/rmq_prep.sv @@
// ----------------------------------------------------------------------------
// rmq_prep
// Entry stage: diagonal sums, clamp at zero, radicand alignment and the
// three sign differences.
// ----------------------------------------------------------------------------
module rmq_prep (
	input  logic               clk,
	input  logic               arst_n,
	input  logic               start,
	input  rmq_pkg::mat_t      mat,
	output logic               vld_s1,
	output rmq_pkg::sq_stage_t prep_s1
);

	logic signed [rmq_pkg::SUM_W-1:0] one;
	logic signed [rmq_pkg::SUM_W-1:0] e00, e11, e22;
	logic signed [rmq_pkg::SUM_W-1:0] sum [rmq_pkg::LANES];
	logic signed [rmq_pkg::IN_W:0]    dx, dy, dz;
	rmq_pkg::sq_stage_t               prep;

	assign one = rmq_pkg::SUM_W'(1) <<< rmq_pkg::FRAC_BITS;
	assign e00 = rmq_pkg::SUM_W'(mat.r00);
	assign e11 = rmq_pkg::SUM_W'(mat.r11);
	assign e22 = rmq_pkg::SUM_W'(mat.r22);

	assign sum[rmq_pkg::LANE_W] = one + e00 + e11 + e22;
	assign sum[rmq_pkg::LANE_X] = one + e00 - e11 - e22;
	assign sum[rmq_pkg::LANE_Y] = one - e00 + e11 - e22;
	assign sum[rmq_pkg::LANE_Z] = one - e00 - e11 + e22;

	assign dx = (rmq_pkg::IN_W+1)'(mat.r21) - (rmq_pkg::IN_W+1)'(mat.r12);
	assign dy = (rmq_pkg::IN_W+1)'(mat.r02) - (rmq_pkg::IN_W+1)'(mat.r20);
	assign dz = (rmq_pkg::IN_W+1)'(mat.r10) - (rmq_pkg::IN_W+1)'(mat.r01);

	always_comb begin
		prep.neg[rmq_pkg::SGN_X] = dx[rmq_pkg::IN_W];
		prep.neg[rmq_pkg::SGN_Y] = dy[rmq_pkg::IN_W];
		prep.neg[rmq_pkg::SGN_Z] = dz[rmq_pkg::IN_W];
		for (int k = 0; k < rmq_pkg::LANES; k++) begin
			prep.lane[k].rem  = '0;
			prep.lane[k].root = '0;
			if (sum[k][rmq_pkg::SUM_W-1]) begin
				prep.lane[k].rad = '0;
			end else begin
				prep.lane[k].rad = rmq_pkg::RAD_W'(sum[k][rmq_pkg::MAG_W-1:0])
					<< (rmq_pkg::FRAC_BITS - 2);
			end
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_s1 <= 1'b0;
		end else begin
			vld_s1 <= start;
		end
	end

	always_ff @(posedge clk) begin
		prep_s1 <= prep;
	end

endmodule

@@ src/rmq_sqrt_step.sv @@
// ----------------------------------------------------------------------------
// rmq_sqrt_step
// Digit-by-digit integer square root: resolves a fixed number of root bits
// of one lane per pipeline stage.
// ----------------------------------------------------------------------------
module rmq_sqrt_step (
	input  rmq_pkg::lane_t lane_in,
	output rmq_pkg::lane_t lane_out
);

	always_comb begin
		rmq_pkg::lane_t             cur;
		logic [rmq_pkg::REM_W-1:0]  trial;
		logic [rmq_pkg::REM_W-1:0]  test;
		cur = lane_in;
		for (int j = 0; j < rmq_pkg::SQ_STEPS; j++) begin
			trial   = {cur.rem[rmq_pkg::REM_W-3:0], cur.rad[rmq_pkg::RAD_W-1 -: 2]};
			test    = {1'b0, cur.root, 2'b01};
			cur.rad = {cur.rad[rmq_pkg::RAD_W-3:0], 2'b00};
			if (trial >= test) begin
				cur.rem  = trial - test;
				cur.root = {cur.root[rmq_pkg::ROOT_W-2:0], 1'b1};
			end else begin
				cur.rem  = trial;
				cur.root = {cur.root[rmq_pkg::ROOT_W-2:0], 1'b0};
			end
		end
		lane_out = cur;
	end

endmodule

@@ src/rmq_out.sv @@
// ----------------------------------------------------------------------------
// rmq_out
// Output stage: saturate each root, apply the component signs and register
// the quaternion with its strobe.
// ----------------------------------------------------------------------------
module rmq_out (
	input  logic               clk,
	input  logic               arst_n,
	input  logic               vld,
	input  rmq_pkg::sq_stage_t fin,
	output logic               done,
	output rmq_pkg::quat_t     quat
);

	logic [rmq_pkg::QW_W-1:0]      mag [rmq_pkg::LANES];
	logic signed [rmq_pkg::IN_W-1:0] sx, sy, sz;
	logic                          done_q;
	rmq_pkg::quat_t                quat_q;

	always_comb begin
		for (int k = 0; k < rmq_pkg::LANES; k++) begin
			if (fin.lane[k].root > rmq_pkg::ROOT_W'(rmq_pkg::MAG_MAX)) begin
				mag[k] = rmq_pkg::QW_W'(rmq_pkg::MAG_MAX);
			end else begin
				mag[k] = fin.lane[k].root[rmq_pkg::QW_W-1:0];
			end
		end
	end

	assign sx = fin.neg[rmq_pkg::SGN_X] ? -{1'b0, mag[rmq_pkg::LANE_X]}
		: {1'b0, mag[rmq_pkg::LANE_X]};
	assign sy = fin.neg[rmq_pkg::SGN_Y] ? -{1'b0, mag[rmq_pkg::LANE_Y]}
		: {1'b0, mag[rmq_pkg::LANE_Y]};
	assign sz = fin.neg[rmq_pkg::SGN_Z] ? -{1'b0, mag[rmq_pkg::LANE_Z]}
		: {1'b0, mag[rmq_pkg::LANE_Z]};

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			done_q <= 1'b0;
		end else begin
			done_q <= vld;
		end
	end

	always_ff @(posedge clk) begin
		quat_q.qw <= mag[rmq_pkg::LANE_W];
		quat_q.qx <= sx;
		quat_q.qy <= sy;
		quat_q.qz <= sz;
	end

	assign done = done_q;
	assign quat = quat_q;

endmodule
